// File: rtl/clnws_pkg.sv
// shared types and constants for the 4-bit character lcd write sequencer
// no dependencies; imported by clnws_core and the top level
package clnws_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;
    localparam logic [1:0] OP_INIT = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_E_PULSE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIB_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_UP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_CTRL = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] RST_E_PULSE   = 16'd1000;
    localparam logic [15:0] RST_NIB_GAP   = 16'd200;
    localparam logic [15:0] RST_SETTLE    = 16'd2000;
    localparam logic [15:0] RST_POWER_UP  = 16'd50000;
    localparam logic [3:0]  RST_DISP_CTRL = 4'd12;

    // init byte sequence
    localparam logic [7:0] INIT_FUNC_A   = 8'h33;
    localparam logic [7:0] INIT_FUNC_B   = 8'h32;
    localparam logic [7:0] INIT_FUNC_4B  = 8'h28;
    localparam logic [7:0] DISP_CTRL_BIT = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;

    typedef struct packed {
        logic [15:0] e_pulse_ticks;
        logic [15:0] nibble_gap_ticks;
        logic [15:0] command_settle_ticks;
        logic [15:0] power_up_ticks;
        logic [3:0]  display_control;
    } t_cfg;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       register_select;
        logic       read_write;
        logic       enable;
        logic       busy_res;
        logic       rejected;
    } t_result;

endpackage

// File: rtl/clnws_core.sv
// sequencer state and next-state logic for the lcd nibble writer
// depends on clnws_pkg; one state update per accepted beat
module clnws_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_byte_value,
    input  clnws_pkg::t_cfg   i_cfg,
    output clnws_pkg::t_result o_result
);
    import clnws_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_HI    = 3'd2;
    localparam logic [2:0] PH_GAP   = 3'd3;
    localparam logic [2:0] PH_LO    = 3'd4;
    localparam logic [2:0] PH_SETTL = 3'd5;

    localparam logic [3:0] INIT_ACTIONS = 4'd10;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] wait_count;
        logic [7:0]  held_byte;
        logic        held_select;
        logic [3:0]  init_step;
        logic [3:0]  nibble_out;
        logic        enable_out;
    } t_state;

    function automatic t_state begin_byte(t_state s, logic [7:0] b, logic sel, t_cfg c);
        t_state t;
        t = s;
        t.held_byte   = b;
        t.held_select = sel;
        t.nibble_out  = b[7:4];
        t.enable_out  = 1'b1;
        t.phase       = PH_HI;
        t.wait_count  = c.e_pulse_ticks;
        return t;
    endfunction

    function automatic t_state begin_wait(t_state s, logic [15:0] n);
        t_state t;
        t = s;
        t.enable_out = 1'b0;
        t.phase      = PH_WAIT;
        t.wait_count = n;
        return t;
    endfunction

    function automatic t_state init_action(t_state s, logic [3:0] k, t_cfg c);
        t_state t;
        t = s;
        t.init_step = k + 4'd1;
        case (k)
            4'd0:    t = begin_wait(t, c.power_up_ticks);
            4'd1:    t = begin_byte(t, INIT_FUNC_A, 1'b0, c);
            4'd2:    t = begin_byte(t, INIT_FUNC_B, 1'b0, c);
            4'd3:    t = begin_byte(t, INIT_FUNC_4B, 1'b0, c);
            4'd4:    t = begin_wait(t, c.e_pulse_ticks);
            4'd5:    t = begin_byte(t, DISP_CTRL_BIT | {4'h0, c.display_control}, 1'b0, c);
            4'd6:    t = begin_wait(t, c.e_pulse_ticks);
            4'd7:    t = begin_byte(t, CMD_CLEAR, 1'b0, c);
            4'd8:    t = begin_wait(t, c.command_settle_ticks);
            default: t = begin_byte(t, CMD_ENTRY, 1'b0, c);
        endcase
        return t;
    endfunction

    function automatic t_state advance(t_state s, t_cfg c);
        t_state t;
        t = s;
        if (s.wait_count > 16'd1) begin
            t.wait_count = s.wait_count - 16'd1;
        end else begin
            unique case (s.phase)
                PH_HI: begin
                    t.enable_out = 1'b0;
                    t.phase      = PH_GAP;
                    t.wait_count = c.nibble_gap_ticks;
                end
                PH_GAP: begin
                    t.nibble_out = s.held_byte[3:0];
                    t.enable_out = 1'b1;
                    t.phase      = PH_LO;
                    t.wait_count = c.e_pulse_ticks;
                end
                PH_LO: begin
                    t.enable_out = 1'b0;
                    t.phase      = PH_SETTL;
                    t.wait_count = c.command_settle_ticks;
                end
                default: begin
                    // segment done: next init action or back to idle
                    if (s.init_step != 4'd0 && s.init_step < INIT_ACTIONS) begin
                        t = init_action(s, s.init_step, c);
                    end else begin
                        t.init_step  = 4'd0;
                        t.enable_out = 1'b0;
                        t.phase      = PH_IDLE;
                        t.wait_count = 16'd0;
                    end
                end
            endcase
        end
        return t;
    endfunction

    t_state r_state;
    t_state n_state;
    logic   busy;
    logic   rejected;

    assign busy = (r_state.phase != PH_IDLE);

    always_comb begin
        n_state  = r_state;
        rejected = 1'b0;
        if (i_operation == OP_TICK) begin
            if (busy) begin
                n_state = advance(r_state, i_cfg);
            end
        end else if (busy) begin
            rejected = 1'b1;
        end else if (i_operation == OP_INIT) begin
            n_state.held_select = 1'b0;
            n_state = init_action(n_state, 4'd0, i_cfg);
        end else begin
            n_state.init_step = 4'd0;
            n_state = begin_byte(n_state, i_byte_value, (i_operation == OP_DATA), i_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    // result shows the pins after this beat
    always_comb begin
        o_result.data_nibble     = n_state.nibble_out;
        o_result.register_select = n_state.held_select;
        o_result.read_write      = 1'b0;
        o_result.enable          = n_state.enable_out;
        o_result.busy_res        = (n_state.phase != PH_IDLE);
        o_result.rejected        = rejected;
    end

endmodule

// File: rtl/char_lcd_nibble_write_sequencer_unit.sv
// top level: 4-bit character lcd write sequencer with config port and skid output
// depends on clnws_pkg and clnws_core
// a result is registered in the output register, or in the skid while that is held
// throughput: one beat per cycle while o_in_stall is low; one short state step per beat
// a two-entry output buffer (output register plus skid) lets input keep flowing
// reset clears the sequencer to idle, loads config defaults and empties the buffer
module char_lcd_nibble_write_sequencer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [7:0]                         i_byte_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [3:0]                         o_data_nibble,
    output logic                               o_register_select,
    output logic                               o_read_write,
    output logic                               o_enable,
    output logic                               o_busy_res,
    output logic                               o_rejected,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [clnws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clnws_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import clnws_pkg::*;

    t_cfg    r_cfg;
    t_result core_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_accept;
    logic    out_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid & ~r_skid_valid;
    assign out_take    = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.e_pulse_ticks        <= RST_E_PULSE;
            r_cfg.nibble_gap_ticks     <= RST_NIB_GAP;
            r_cfg.command_settle_ticks <= RST_SETTLE;
            r_cfg.power_up_ticks       <= RST_POWER_UP;
            r_cfg.display_control      <= RST_DISP_CTRL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_E_PULSE:   r_cfg.e_pulse_ticks        <= i_cfg_data;
                REG_NIB_GAP:   r_cfg.nibble_gap_ticks     <= i_cfg_data;
                REG_SETTLE:    r_cfg.command_settle_ticks <= i_cfg_data;
                REG_POWER_UP:  r_cfg.power_up_ticks       <= i_cfg_data;
                REG_DISP_CTRL: r_cfg.display_control      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    clnws_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_operation  (i_operation),
        .i_byte_value (i_byte_value),
        .i_cfg        (r_cfg),
        .o_result     (core_result)
    );

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= core_result;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid <= core_result;
            end else begin
                r_out <= core_result;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_data_nibble     = r_out.data_nibble;
    assign o_register_select = r_out.register_select;
    assign o_read_write      = r_out.read_write;
    assign o_enable          = r_out.enable;
    assign o_busy_res        = r_out.busy_res;
    assign o_rejected        = r_out.rejected;

endmodule
